/* hdl/ssc_pkg.sv */
// Shared types and constants for the state-space controller.
package ssc_pkg;

	typedef enum logic [1:0] {
		CMD_COEF   = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic [2:0] TBL_A  = 3'd0;
	localparam logic [2:0] TBL_B  = 3'd1;
	localparam logic [2:0] TBL_C  = 3'd2;
	localparam logic [2:0] TBL_D  = 3'd3;
	localparam logic [2:0] TBL_LO = 3'd4;
	localparam logic [2:0] TBL_HI = 3'd5;

	localparam logic [2:0] REG_STATE_SIZE  = 3'd0;
	localparam logic [2:0] REG_ERROR_SIZE  = 3'd1;
	localparam logic [2:0] REG_OUTPUT_SIZE = 3'd2;
	localparam logic [2:0] REG_ERROR_DIR   = 3'd3;
	localparam logic [2:0] REG_SAT_MODE    = 3'd4;
	localparam logic [2:0] REG_SAT_MIN     = 3'd5;
	localparam logic [2:0] REG_SAT_MAX     = 3'd6;

	localparam logic [1:0] SAT_NONE   = 2'd0;
	localparam logic [1:0] SAT_COMMON = 2'd1;
	localparam logic [1:0] SAT_PEROUT = 2'd2;

	typedef struct packed {
		logic [3:0]  state_size;
		logic [2:0]  error_size;
		logic [2:0]  output_size;
		logic        error_direct;
		logic [1:0]  sat_mode;
		logic [15:0] sat_min;
		logic [15:0] sat_max;
	} cfg_t;

endpackage

/* hdl/ssc_cfg.sv */
// APB register file for the state-space controller.
module ssc_cfg import ssc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_size   <= 4'd1;
			cfg_q.error_size   <= 3'd1;
			cfg_q.output_size  <= 3'd1;
			cfg_q.error_direct <= 1'b1;
			cfg_q.sat_mode     <= SAT_NONE;
			cfg_q.sat_min      <= 16'h8000;
			cfg_q.sat_max      <= 16'h7fff;
		end else if (wr) begin
			unique case (idx)
				REG_STATE_SIZE:  cfg_q.state_size   <= pwdata[3:0];
				REG_ERROR_SIZE:  cfg_q.error_size   <= pwdata[2:0];
				REG_OUTPUT_SIZE: cfg_q.output_size  <= pwdata[2:0];
				REG_ERROR_DIR:   cfg_q.error_direct <= pwdata[0];
				REG_SAT_MODE:    cfg_q.sat_mode     <= pwdata[1:0];
				REG_SAT_MIN:     cfg_q.sat_min      <= pwdata[15:0];
				REG_SAT_MAX:     cfg_q.sat_max      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_STATE_SIZE:  prdata = {28'd0, cfg_q.state_size};
			REG_ERROR_SIZE:  prdata = {29'd0, cfg_q.error_size};
			REG_OUTPUT_SIZE: prdata = {29'd0, cfg_q.output_size};
			REG_ERROR_DIR:   prdata = {31'd0, cfg_q.error_direct};
			REG_SAT_MODE:    prdata = {30'd0, cfg_q.sat_mode};
			REG_SAT_MIN:     prdata = {16'd0, cfg_q.sat_min};
			REG_SAT_MAX:     prdata = {16'd0, cfg_q.sat_max};
			default:         prdata = '0;
		endcase
	end

endmodule

/* hdl/state_space_controller.sv */
// Top level: discrete state-space controller, memory-centered with one MAC.
// Coefficient writes and sample elements are taken in the idle state; a clear
// also starts a sweep that zeroes all NX_MAX state entries. The final element
// starts the output and next-state computation, paced by the single read port
// of the coefficient memory; results held off by m_tready add their wait to it.
// Reset clears state with the same sweep, counts, config.
module state_space_controller import ssc_pkg::*; #(
	parameter int NX_MAX    = 8,
	parameter int NE_MAX    = 4,
	parameter int NU_MAX    = 4,
	parameter int COEF_FRAC = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[1:0], coef_table[4:2], coef_row[7:5], coef_col[10:8],
	// coef_value[26:11], ref_or_error[42:27], measurement[58:43]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// control_value[15:0], output_index[17:16], clipped[18], sample_index[34:19]
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	localparam int XW   = $clog2(NX_MAX) > 0 ? $clog2(NX_MAX) : 1;
	localparam int EW   = $clog2(NE_MAX) > 0 ? $clog2(NE_MAX) : 1;
	localparam int UW   = $clog2(NU_MAX) > 0 ? $clog2(NU_MAX) : 1;
	localparam int OFF_A  = 0;
	localparam int OFF_B  = OFF_A + NX_MAX * NX_MAX;
	localparam int OFF_C  = OFF_B + NX_MAX * NE_MAX;
	localparam int OFF_D  = OFF_C + NU_MAX * NX_MAX;
	localparam int OFF_LO = OFF_D + NU_MAX * NE_MAX;
	localparam int OFF_HI = OFF_LO + NU_MAX;
	localparam int DEPTH  = OFF_HI + NU_MAX;
	localparam int AW     = $clog2(DEPTH);
	localparam int ACCW   = 48;
	localparam int OIW    = (UW < 2) ? UW : 2;

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_MAC  = 7'b0000100,
		ST_LIM  = 7'b0001000,
		ST_FIN  = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_COPY = 7'b1000000
	} st_t;

	cfg_t cfg;
	ssc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);
	assign pready = 1'b1;

	logic [1:0]  in_cmd;
	logic [2:0]  in_tbl, in_row, in_col;
	logic [15:0] in_val, in_ref, in_meas;
	assign in_cmd  = s_tdata[1:0];
	assign in_tbl  = s_tdata[4:2];
	assign in_row  = s_tdata[7:5];
	assign in_col  = s_tdata[10:8];
	assign in_val  = s_tdata[26:11];
	assign in_ref  = s_tdata[42:27];
	assign in_meas = s_tdata[58:43];

	// effective sizes
	logic [4:0] nx, ne, nu;
	always_comb begin
		nx = (cfg.state_size == 0) ? 5'd1 :
			(32'(cfg.state_size) > NX_MAX ? 5'(NX_MAX) : 5'(cfg.state_size));
		ne = (cfg.error_size == 0) ? 5'd1 :
			(32'(cfg.error_size) > NE_MAX ? 5'(NE_MAX) : 5'(cfg.error_size));
		nu = (cfg.output_size == 0) ? 5'd1 :
			(32'(cfg.output_size) > NU_MAX ? 5'(NU_MAX) : 5'(cfg.output_size));
	end

	// memories
	logic [15:0] coef_mem [DEPTH];
	logic [23:0] x_mem [NX_MAX];
	logic [23:0] nx_mem [NX_MAX];
	logic [15:0] e_mem [NE_MAX];

	st_t         st_q;
	logic [2:0]  ecnt_q;
	logic [15:0] step_q;
	logic [4:0]  row_q, col_q;
	logic        phase_q;      // 0: output rows, 1: state rows
	logic        rd_v_s1;
	logic        rd_x_s1;
	logic [ACCW-1:0] acc_q;
	logic [15:0] c_rd_s1, e_rd_s1;
	logic [23:0] x_rd_s1, n_rd_s1;
	logic [XW-1:0] init_q;
	logic [15:0] lo_q, hi_q;
	logic        limrd_q;

	logic        acc_in;
	assign acc_in  = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE);

	// coefficient write decode
	logic        cw_ok;
	logic [AW-1:0] cw_addr;
	always_comb begin
		cw_ok = 1'b0;
		cw_addr = '0;
		unique case (in_tbl)
			TBL_A: begin
				cw_ok = 32'(in_row) < NX_MAX && 32'(in_col) < NX_MAX;
				cw_addr = AW'(OFF_A + 32'(in_row) * NX_MAX + 32'(in_col));
			end
			TBL_B: begin
				cw_ok = 32'(in_row) < NX_MAX && 32'(in_col) < NE_MAX;
				cw_addr = AW'(OFF_B + 32'(in_row) * NE_MAX + 32'(in_col));
			end
			TBL_C: begin
				cw_ok = 32'(in_row) < NU_MAX && 32'(in_col) < NX_MAX;
				cw_addr = AW'(OFF_C + 32'(in_row) * NX_MAX + 32'(in_col));
			end
			TBL_D: begin
				cw_ok = 32'(in_row) < NU_MAX && 32'(in_col) < NE_MAX;
				cw_addr = AW'(OFF_D + 32'(in_row) * NE_MAX + 32'(in_col));
			end
			TBL_LO: begin
				cw_ok = 32'(in_row) < NU_MAX;
				cw_addr = AW'(OFF_LO + 32'(in_row));
			end
			TBL_HI: begin
				cw_ok = 32'(in_row) < NU_MAX;
				cw_addr = AW'(OFF_HI + 32'(in_row));
			end
			default: cw_ok = 1'b0;
		endcase
	end
	logic cw_en;
	assign cw_en = acc_in && in_cmd == CMD_COEF && cw_ok;

	// error formation
	logic signed [16:0] diff;
	logic [15:0] e_val;
	always_comb begin
		diff = $signed({in_ref[15], in_ref}) - $signed({in_meas[15], in_meas});
		if (cfg.error_direct) e_val = in_ref;
		else if (diff > 17'sd32767) e_val = 16'h7fff;
		else if (diff < -17'sd32768) e_val = 16'h8000;
		else e_val = diff[15:0];
	end
	logic smp, smp_end;
	assign smp = acc_in && in_cmd == CMD_SAMPLE;
	assign smp_end = smp && !(5'(ecnt_q) + 5'd1 < ne);

	// MAC read address
	logic [4:0] nterm;
	logic       in_x;
	logic [AW-1:0] rd_addr;
	always_comb begin
		nterm = nx + ne;
		in_x = col_q < nx;
		if (!phase_q)
			rd_addr = in_x ? AW'(OFF_C + 32'(row_q) * NX_MAX + 32'(col_q))
				: AW'(OFF_D + 32'(row_q) * NE_MAX + 32'(col_q - nx));
		else
			rd_addr = in_x ? AW'(OFF_A + 32'(row_q) * NX_MAX + 32'(col_q))
				: AW'(OFF_B + 32'(row_q) * NE_MAX + 32'(col_q - nx));
		if (st_q == ST_LIM)
			rd_addr = limrd_q ? AW'(OFF_HI + 32'(row_q)) : AW'(OFF_LO + 32'(row_q));
	end

	always_ff @(posedge clk) begin
		if (cw_en) coef_mem[cw_addr] <= in_val;
		c_rd_s1 <= coef_mem[rd_addr];
		x_rd_s1 <= x_mem[col_q[XW-1:0]];
		e_rd_s1 <= e_mem[EW'(col_q - nx)];
		n_rd_s1 <= nx_mem[row_q[XW-1:0]];
		if (smp && 32'(ecnt_q) < NE_MAX) e_mem[ecnt_q[EW-1:0]] <= e_val;
	end

	// product and rounding
	logic signed [40:0] prod;
	assign prod = rd_x_s1 ? $signed(c_rd_s1) * $signed(x_rd_s1)
		: $signed(c_rd_s1) * $signed({{8{e_rd_s1[15]}}, e_rd_s1});
	logic signed [ACCW-1:0] rnd;
	always_comb begin
		if (COEF_FRAC > 0)
			rnd = ($signed(acc_q) + (ACCW'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		else
			rnd = $signed(acc_q);
	end

	// output saturation
	logic [15:0] v16, lo_v, hi_v, vout;
	logic        clip16, clipo;
	always_comb begin
		clip16 = rnd > 32767 || rnd < -32768;
		v16 = rnd > 32767 ? 16'h7fff : (rnd < -32768 ? 16'h8000 : rnd[15:0]);
		lo_v = cfg.sat_mode == SAT_COMMON ? cfg.sat_min : lo_q;
		hi_v = cfg.sat_mode == SAT_COMMON ? cfg.sat_max : hi_q;
		vout = v16;
		clipo = clip16;
		if (cfg.sat_mode == SAT_COMMON || cfg.sat_mode == SAT_PEROUT) begin
			if ($signed(v16) > $signed(hi_v)) begin
				vout = hi_v;
				clipo = clipo || hi_v != v16;
			end else if ($signed(v16) < $signed(lo_v)) begin
				vout = lo_v;
				clipo = 1'b1;
			end
		end
	end
	logic [23:0] x_sat;
	assign x_sat = rnd > 8388607 ? 24'h7fffff : (rnd < -8388608 ? 24'h800000 : rnd[23:0]);

	logic rd_go;
	assign rd_go = st_q == ST_MAC && col_q < nterm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			init_q <= '0;
			ecnt_q <= '0;
			step_q <= '0;
			row_q <= '0;
			col_q <= '0;
			phase_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_x_s1 <= 1'b0;
			limrd_q <= 1'b0;
			acc_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			rd_v_s1 <= rd_go;
			rd_x_s1 <= in_x;
			unique case (st_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (32'(init_q) == NX_MAX - 1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc_in && in_cmd == CMD_CLEAR) begin
						ecnt_q <= '0;
						step_q <= '0;
						init_q <= '0;
						st_q <= ST_INIT;
					end else if (smp) begin
						if (smp_end) begin
							ecnt_q <= '0;
							row_q <= '0;
							col_q <= '0;
							phase_q <= 1'b0;
							acc_q <= '0;
							st_q <= ST_MAC;
						end else ecnt_q <= ecnt_q + 3'd1;
					end
				end
				ST_MAC: begin
					if (rd_go) col_q <= col_q + 5'd1;
					if (rd_v_s1) acc_q <= acc_q + ACCW'(prod);
					if (!rd_go && !rd_v_s1) begin
						if (!phase_q) begin
							limrd_q <= 1'b0;
							st_q <= ST_LIM;
						end else st_q <= ST_FIN;
					end
				end
				ST_LIM: begin
					// two reads: low then high limit
					if (limrd_q) begin
						lo_q <= c_rd_s1;
						st_q <= ST_OUT;
						limrd_q <= 1'b0;
					end else limrd_q <= 1'b1;
				end
				ST_OUT: begin
					if (!limrd_q) begin
						hi_q <= c_rd_s1;
						limrd_q <= 1'b1;
					end else if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						m_tdata <= {5'd0, step_q, clipo, 2'(row_q[OIW-1:0]), vout};
						m_tlast <= row_q + 5'd1 == nu;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						limrd_q <= 1'b0;
						col_q <= '0;
						acc_q <= '0;
						if (row_q + 5'd1 == nu) begin
							row_q <= '0;
							phase_q <= 1'b1;
						end else row_q <= row_q + 5'd1;
						st_q <= ST_MAC;
					end
				end
				ST_FIN: begin
					acc_q <= '0;
					col_q <= '0;
					if (row_q + 5'd1 == nx) begin
						row_q <= '0;
						st_q <= ST_COPY;
					end else begin
						row_q <= row_q + 5'd1;
						st_q <= ST_MAC;
					end
				end
				ST_COPY: begin
					limrd_q <= !limrd_q;
					if (limrd_q) begin
						if (row_q + 5'd1 == nx) begin
							row_q <= '0;
							step_q <= step_q + 16'd1;
							st_q <= ST_IDLE;
						end else row_q <= row_q + 5'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_INIT) x_mem[init_q] <= '0;
		else if (st_q == ST_COPY && limrd_q) x_mem[row_q[XW-1:0]] <= n_rd_s1;
		if (st_q == ST_FIN) nx_mem[row_q[XW-1:0]] <= x_sat;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		5'(ecnt_q) < 5'd8) else $error("element count overflow");

endmodule

/* verif/tb.sv */
// Self-checking testbench for state_space_controller against a behavioral model.
module tb;
	import ssc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;

	state_space_controller dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  idx;
		logic        lst;
		logic        clip;
		logic [15:0] sample;
	} ctrl_out_t;

	// controller model state
	longint coefs [152];
	longint xs [8];
	longint errs [4];
	int unsigned elem_cnt;
	logic [15:0] steps;
	int unsigned r_nx, r_ne, r_nu, r_direct, r_sat;
	longint r_min, r_max;
	ctrl_out_t expected_q[$];
	logic [63:0] pending_q[$];

	int mismatches = 0;
	int n_results = 0;
	int n_items = 0;
	bit hold_off = 1'b0;

	function automatic int unsigned clip_size(int unsigned v, int unsigned mx);
		if (v == 0) return 1;
		return v > mx ? mx : v;
	endfunction

	function automatic longint round_q12(longint acc);
		acc += 2048;
		return acc >>> 12;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic apply_item(logic [63:0] d);
		cmd_t c;
		int unsigned tbl, row, col, rows, cols, off, nx, ne, nu;
		longint e, acc, v, lo, hi;
		bit clp;
		ctrl_out_t r;
		longint nxt [8];
		c = cmd_t'(d[1:0]);
		tbl = d[4:2]; row = d[7:5]; col = d[10:8];
		if (c == CMD_COEF) begin
			rows = 0;
			case (tbl)
				TBL_A: begin rows = 8; cols = 8; off = 0; end
				TBL_B: begin rows = 8; cols = 4; off = 64; end
				TBL_C: begin rows = 4; cols = 8; off = 96; end
				TBL_D: begin rows = 4; cols = 4; off = 128; end
				TBL_LO: begin rows = 4; cols = 1; off = 144; col = 0; end
				TBL_HI: begin rows = 4; cols = 1; off = 148; col = 0; end
				default: rows = 0;
			endcase
			if (row < rows && col < cols)
				coefs[off + row * cols + col] = longint'($signed(d[26:11]));
		end else if (c == CMD_CLEAR) begin
			foreach (xs[i]) xs[i] = 0;
			steps = '0;
			elem_cnt = 0;
		end else if (c == CMD_SAMPLE) begin
			if (r_direct != 0)
				e = longint'($signed(d[42:27]));
			else
				e = sat(longint'($signed(d[42:27])) - longint'($signed(d[58:43])),
					-32768, 32767);
			nx = clip_size(r_nx, 8); ne = clip_size(r_ne, 4); nu = clip_size(r_nu, 4);
			if (elem_cnt < 4) errs[elem_cnt] = e;
			if (elem_cnt + 1 < ne) begin
				elem_cnt = (elem_cnt + 1) & 7;
			end else begin
				elem_cnt = 0;
				for (int k = 0; k < nu; k++) begin
					acc = 0;
					for (int j = 0; j < nx; j++) acc += coefs[96 + k * 8 + j] * xs[j];
					for (int j = 0; j < ne; j++) acc += coefs[128 + k * 4 + j] * errs[j];
					acc = round_q12(acc);
					v = sat(acc, -32768, 32767);
					clp = (v != acc);
					if (r_sat == SAT_COMMON || r_sat == SAT_PEROUT) begin
						lo = (r_sat == SAT_COMMON) ? r_min : coefs[144 + k];
						hi = (r_sat == SAT_COMMON) ? r_max : coefs[148 + k];
						if (v > hi) begin clp = 1; v = hi; end
						else if (v < lo) begin clp = 1; v = lo; end
					end
					r.value = v[15:0]; r.idx = k[1:0]; r.lst = (k + 1 == nu);
					r.clip = clp; r.sample = steps;
					expected_q.push_back(r);
				end
				for (int k = 0; k < nx; k++) begin
					acc = 0;
					for (int j = 0; j < nx; j++) acc += coefs[k * 8 + j] * xs[j];
					for (int j = 0; j < ne; j++) acc += coefs[64 + k * 4 + j] * errs[j];
					nxt[k] = sat(round_q12(acc), -8388608, 8388607);
				end
				for (int k = 0; k < nx; k++) xs[k] = nxt[k];
				steps = steps + 16'd1;
			end
		end
	endtask

	function automatic logic [63:0] pack_item(cmd_t c, int unsigned tbl, int unsigned row,
			int unsigned col, logic [15:0] cv, logic [15:0] re, logic [15:0] ms);
		logic [63:0] d;
		d = '0;
		d[1:0] = c; d[4:2] = tbl[2:0]; d[7:5] = row[2:0]; d[10:8] = col[2:0];
		d[26:11] = cv; d[42:27] = re; d[58:43] = ms;
		return d;
	endfunction

	function automatic logic [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 400) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	// coefficients kept modest mostly so the state does not pin at its rails
	function automatic logic [15:0] rnd_coef();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 4096)) - 2048);
	endfunction

	task automatic push_coef(int unsigned tbl, int unsigned row, int unsigned col,
			logic [15:0] v);
		pending_q.push_back(pack_item(CMD_COEF, tbl, row, col, v, rnd16(), rnd16()));
	endtask

	task automatic push_sample(logic [15:0] re, logic [15:0] ms);
		pending_q.push_back(pack_item(CMD_SAMPLE, $urandom_range(0, 7),
			$urandom_range(0, 7), $urandom_range(0, 7), rnd16(), re, ms));
	endtask

	task automatic load_all_coefs();
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) push_coef(TBL_A, r, c, rnd_coef());
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 4; c++) push_coef(TBL_B, r, c, rnd_coef());
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 8; c++) push_coef(TBL_C, r, c, rnd_coef());
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) push_coef(TBL_D, r, c, rnd_coef());
		for (int r = 0; r < 4; r++)
			push_coef(TBL_LO, r, $urandom_range(0, 7), 16'(-$urandom_range(0, 20000)));
		for (int r = 0; r < 4; r++)
			push_coef(TBL_HI, r, $urandom_range(0, 7), 16'($urandom_range(0, 20000)));
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_STATE_SIZE: r_nx = val[3:0];
			REG_ERROR_SIZE: r_ne = val[2:0];
			REG_OUTPUT_SIZE: r_nu = val[2:0];
			REG_ERROR_DIR: r_direct = val[0];
			REG_SAT_MODE: r_sat = val[1:0];
			REG_SAT_MIN: r_min = longint'($signed(val[15:0]));
			REG_SAT_MAX: r_max = longint'($signed(val[15:0]));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// driver
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_item(s_tdata);
				n_items++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_q.pop_front();
					gap = ($urandom_range(0, 3) == 0) ?
						(($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2)) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	ctrl_out_t got, want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[15:0]; got.idx = m_tdata[17:16]; got.clip = m_tdata[18];
				got.sample = m_tdata[34:19]; got.lst = m_tlast;
				n_results++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer %p", got);
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
					end
				end
			end
			m_tready <= hold_off ? 1'b0 : ($urandom_range(0, 4) != 0 ||
				$urandom_range(0, 1) == 0);
		end
	end

	// long receiver hold-off while directed samples are still queued
	initial begin
		wait (n_items > 160);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#3000000;
		$display("state_space_controller verification failed");
		$finish;
	end

	initial begin
		foreach (coefs[i]) coefs[i] = 0;
		foreach (xs[i]) xs[i] = 0;
		foreach (errs[i]) errs[i] = 0;
		elem_cnt = 0; steps = '0;
		r_nx = 1; r_ne = 1; r_nu = 1; r_direct = 1; r_sat = SAT_NONE;
		r_min = -32768; r_max = 32767;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (20) @(posedge clk);

		// directed: full store load, extremes, invalid writes, clear, cmd 3
		load_all_coefs();
		drain();
		reg_write(REG_STATE_SIZE, 8); reg_write(REG_ERROR_SIZE, 4);
		reg_write(REG_OUTPUT_SIZE, 4); reg_write(REG_ERROR_DIR, 0);
		reg_write(REG_SAT_MODE, SAT_NONE);
		push_coef(TBL_C, 7, 0, 16'h7fff);
		push_coef(6, 0, 0, 16'h1234);
		push_coef(7, 7, 7, 16'hffff);
		push_coef(TBL_D, 1, 7, 16'h8000);
		push_sample(16'h7fff, 16'h8000); push_sample(16'h8000, 16'h7fff);
		push_sample(16'hffff, 16'h0000); push_sample(16'h0000, 16'hffff);
		push_sample(16'h1000, 16'h0200);
		pending_q.push_back(pack_item(CMD_CLEAR, 7, 7, 7, 16'hffff, 16'hffff, 16'hffff));
		push_sample(16'h7fff, 16'h7fff); push_sample(16'h8000, 16'h8000);
		pending_q.push_back(pack_item(CMD_NONE, 7, 7, 7, 16'hffff, 16'hffff, 16'hffff));
		push_sample(16'h4000, 16'hc000); push_sample(16'h2222, 16'h1111);
		push_sample(16'h0001, 16'h0000); push_sample(16'h7fff, 16'h0001);
		drain();

		// random phases, sizes including zero and over-range
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin reg_write(REG_STATE_SIZE, 0); reg_write(REG_ERROR_SIZE, 0);
					reg_write(REG_OUTPUT_SIZE, 0); end
				1: begin reg_write(REG_STATE_SIZE, 15); reg_write(REG_ERROR_SIZE, 7);
					reg_write(REG_OUTPUT_SIZE, 7); end
				default: begin reg_write(REG_STATE_SIZE, $urandom_range(1, 8));
					reg_write(REG_ERROR_SIZE, $urandom_range(1, 4));
					reg_write(REG_OUTPUT_SIZE, $urandom_range(1, 4)); end
			endcase
			reg_write(REG_ERROR_DIR, $urandom_range(0, 1));
			reg_write(REG_SAT_MODE, ph == 7 ? 3 : ph % 3);
			if (ph == 4) begin
				reg_write(REG_SAT_MIN, 32'h8000); reg_write(REG_SAT_MAX, 32'h7fff);
			end else begin
				reg_write(REG_SAT_MIN, 32'($signed(-$urandom_range(0, 30000))));
				reg_write(REG_SAT_MAX, ph == 5 ? 32'hffff_9000 : $urandom_range(0, 30000));
			end
			for (int i = 0; i < 14; i++) begin
				case ($urandom_range(0, 19))
					0: pending_q.push_back(pack_item(CMD_CLEAR, $urandom_range(0, 7),
						0, 0, rnd16(), rnd16(), rnd16()));
					1: pending_q.push_back(pack_item(CMD_NONE, $urandom_range(0, 7),
						0, 0, rnd16(), rnd16(), rnd16()));
					2, 3: push_coef($urandom_range(0, 7), $urandom_range(0, 7),
						$urandom_range(0, 7), rnd_coef());
					default: push_sample(rnd16(), rnd16());
				endcase
			end
			drain();
		end

		$display("Run covered %0d input transfers and %0d output transfers across",
			n_items, n_results);
		$display("all size extremes, both error forms and every saturation mode.");
		if (mismatches == 0 && expected_q.size() == 0)
			$display("state_space_controller verification clean");
		else
			$display("state_space_controller verification failed");
		$finish;
	end
endmodule

/* sim.f */
hdl/ssc_pkg.sv
hdl/ssc_cfg.sv
hdl/state_space_controller.sv
verif/tb.sv
